// ===== rtl/vrr_pkg.sv =====
// Shared types and constants for the vendor receive to radiotap rewriter.
// No dependencies; every rtl file uses this package by scoped names.
`default_nettype none

package vrr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_MHZ   = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_FLAGS = 2'd1;
    localparam logic [1:0] CFG_HEADER_FLAGS  = 2'd2;

    localparam logic [15:0] RST_CHANNEL_MHZ   = 16'd2437;
    localparam logic [15:0] RST_CHANNEL_FLAGS = 16'h0080;
    localparam logic [7:0]  RST_HEADER_FLAGS  = 8'h10;

    // vendor header layout
    localparam logic [15:0] MIN_FRAME_LEN = 16'd24;
    localparam logic [15:0] IDX_LEN_HI    = 16'd1;
    localparam logic [15:0] IDX_MAGIC_END = 16'd15;
    localparam logic [15:0] IDX_SIGNAL    = 16'd18;
    localparam logic [15:0] IDX_TYPE      = 16'd28;
    localparam logic [7:0]  MAGIC_0       = 8'h4D;  // 'M'
    localparam logic [7:0]  MAGIC_1       = 8'h49;  // 'I'
    localparam logic [7:0]  MAGIC_2       = 8'h54;  // 'T'
    localparam logic [7:0]  MAGIC_3       = 8'h53;  // 'S'
    localparam logic [7:0]  TYPE_REJECT_A = 8'h01;
    localparam logic [7:0]  TYPE_REJECT_B = 8'h05;
    localparam int          TYPE_LONG_BIT = 2;
    localparam logic [5:0]  STRIP_SHORT   = 6'd56;
    localparam logic [5:0]  STRIP_LONG    = 6'd58;

    // burst lengths (last element index)
    localparam logic [3:0] PASS_LAST_IDX = 4'd15;
    localparam logic [3:0] RTAP_LAST_IDX = 4'd14;

    // radiotap header constant bytes
    localparam logic [7:0] RT_LEN_BYTE     = 8'h0f;
    localparam logic [7:0] RT_PRESENT_BYTE = 8'h2a;

    typedef enum logic [2:0] {
        MODE_COLLECT,
        MODE_PASS,
        MODE_SCAN,
        MODE_BODY,
        MODE_SKIP
    } t_mode;

    typedef enum logic [1:0] {
        CMD_BYTE,   // one payload byte
        CMD_DROP,   // drop marker
        CMD_PASS,   // 16 saved head bytes
        CMD_RTAP    // 15-byte radiotap header, data = signal byte
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       last;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/vrr_front.sv =====
// Front end: accepts input bytes, parses the vendor header, issues commands.
// Depends on vrr_pkg.
`default_nettype none

module vrr_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output logic                    o_push,
    output vrr_pkg::t_cmd           o_cmd,
    input  wire logic               i_full,
    input  wire logic               i_burst_done,
    output logic [15:0][7:0]        o_head
);

    logic [15:0]      r_idx, n_idx;
    logic [15:0]      r_len, n_len;
    vrr_pkg::t_mode   r_mode, n_mode;
    logic [7:0]       r_sig, n_sig;
    logic             r_strip58, n_strip58;
    logic             r_burst_pend, n_burst_pend;
    logic [15:0][7:0] r_head;

    logic        accept;
    logic [16:0] idx_p1;
    logic        is_end;
    logic [15:0] new_len;
    logic [5:0]  strip;
    logic        is_magic;
    logic        drop;
    logic        term;

    // hold off a new frame's header while the previous pass burst still reads it
    assign o_stall = i_full || (r_burst_pend && (r_mode == vrr_pkg::MODE_COLLECT));
    assign accept  = i_valid && !o_stall;
    assign o_head  = r_head;

    assign idx_p1   = {1'b0, r_idx} + 17'd1;
    assign is_end   = i_last || ((r_idx >= 16'd2) && (idx_p1 == {1'b0, r_len}));
    assign new_len  = {i_byte, r_head[0]};
    assign strip    = r_strip58 ? vrr_pkg::STRIP_LONG : vrr_pkg::STRIP_SHORT;
    assign is_magic = (r_head[12] == vrr_pkg::MAGIC_0) && (r_head[13] == vrr_pkg::MAGIC_1)
                   && (r_head[14] == vrr_pkg::MAGIC_2) && (i_byte == vrr_pkg::MAGIC_3);

    always_comb begin
        n_idx        = r_idx;
        n_len        = r_len;
        n_mode       = r_mode;
        n_sig        = r_sig;
        n_strip58    = r_strip58;
        o_push       = 1'b0;
        o_cmd.kind   = vrr_pkg::CMD_BYTE;
        o_cmd.data   = i_byte;
        o_cmd.last   = is_end;
        drop         = 1'b0;
        term         = 1'b0;
        if (accept) begin
            unique case (r_mode)
                vrr_pkg::MODE_COLLECT: begin
                    if (r_idx == vrr_pkg::IDX_LEN_HI) begin
                        n_len = new_len;
                        if (new_len < vrr_pkg::MIN_FRAME_LEN) begin
                            drop = 1'b1;
                        end
                    end
                    if (!drop) begin
                        if (r_idx < vrr_pkg::IDX_MAGIC_END) begin
                            drop = i_last;
                        end else if (is_magic) begin
                            o_push     = 1'b1;
                            o_cmd.kind = vrr_pkg::CMD_PASS;
                            n_mode     = vrr_pkg::MODE_PASS;
                            term       = is_end;
                        end else begin
                            n_mode = vrr_pkg::MODE_SCAN;
                            drop   = is_end;
                        end
                    end
                end
                vrr_pkg::MODE_SCAN: begin
                    if (r_idx == vrr_pkg::IDX_SIGNAL) begin
                        n_sig = i_byte;
                    end
                    if ((r_idx == vrr_pkg::IDX_TYPE) && ((i_byte == vrr_pkg::TYPE_REJECT_A)
                            || (i_byte == vrr_pkg::TYPE_REJECT_B))) begin
                        drop = 1'b1;
                    end else begin
                        if ((r_idx == vrr_pkg::IDX_TYPE) && i_byte[vrr_pkg::TYPE_LONG_BIT]) begin
                            n_strip58 = 1'b1;
                        end
                        if (idx_p1 == {11'd0, strip}) begin
                            o_push     = 1'b1;
                            o_cmd.kind = vrr_pkg::CMD_RTAP;
                            o_cmd.data = r_sig;
                            term       = is_end;
                            n_mode     = vrr_pkg::MODE_BODY;
                        end else begin
                            drop = is_end;
                        end
                    end
                end
                vrr_pkg::MODE_PASS, vrr_pkg::MODE_BODY: begin
                    o_push = 1'b1;
                    term   = is_end;
                end
                vrr_pkg::MODE_SKIP: begin
                    term = i_last;
                end
                default: begin
                    term = i_last;
                end
            endcase

            if (drop) begin
                o_push     = 1'b1;
                o_cmd.kind = vrr_pkg::CMD_DROP;
                o_cmd.data = 8'h00;
                o_cmd.last = 1'b1;
                term       = 1'b1;
            end

            if (term) begin
                if (i_last) begin
                    n_idx     = 16'd0;
                    n_mode    = vrr_pkg::MODE_COLLECT;
                    n_strip58 = 1'b0;
                    n_sig     = 8'h00;
                end else begin
                    n_mode = vrr_pkg::MODE_SKIP;
                end
            end else if (r_idx != 16'hFFFF) begin
                n_idx = r_idx + 16'd1;
            end
        end
    end

    assign n_burst_pend = (o_push && (o_cmd.kind == vrr_pkg::CMD_PASS))
                       || (r_burst_pend && !i_burst_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= 16'd0;
            r_len        <= 16'd0;
            r_mode       <= vrr_pkg::MODE_COLLECT;
            r_sig        <= 8'h00;
            r_strip58    <= 1'b0;
            r_burst_pend <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_len        <= n_len;
            r_mode       <= n_mode;
            r_sig        <= n_sig;
            r_strip58    <= n_strip58;
            r_burst_pend <= n_burst_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_mode == vrr_pkg::MODE_COLLECT)) begin
            r_head[r_idx[3:0]] <= i_byte;
        end
    end

    // header bytes are never rewritten while a pass burst still owns them
    a_head_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_burst_pend && (r_mode == vrr_pkg::MODE_COLLECT)) |-> !accept)
        else $error("header overwritten during pass burst");

    // a command only goes out for an accepted byte
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("command issued without input transfer");

    // a frame in collection never has more than 16 header bytes
    a_collect_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == vrr_pkg::MODE_COLLECT) |-> (r_idx <= vrr_pkg::IDX_MAGIC_END))
        else $error("collect index out of range");

endmodule

`default_nettype wire

// ===== rtl/vrr_queue.sv =====
// Small command queue between the front end and the output back end.
// Depends on vrr_pkg. DEPTH must be a power of two, 2 or more.
`default_nettype none

module vrr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire vrr_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output vrr_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    vrr_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty command queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== rtl/vrr_back.sv =====
// Back end: expands queued commands into output bytes behind an output register.
// Depends on vrr_pkg; reads the front end's saved header bytes.
`default_nettype none

module vrr_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire vrr_pkg::t_cmd      i_cmd,
    output logic                    o_pop,
    input  wire logic [15:0][7:0]   i_head,
    input  wire logic [15:0]        i_channel_mhz,
    input  wire logic [15:0]        i_channel_flags,
    input  wire logic [7:0]         i_header_flags,
    output logic                    o_burst_done,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_byte,
    output logic                    o_last,
    output logic                    o_dropped
);

    logic                r_active, n_active;
    vrr_pkg::t_cmd_kind  r_kind, n_kind;
    logic [3:0]          r_pos, n_pos;
    logic                r_last, n_last;
    logic [7:0]          r_sig, n_sig;

    logic                r_ovalid, n_ovalid;
    logic [7:0]          r_obyte, n_obyte;
    logic                r_olast, n_olast;
    logic                r_odrop, n_odrop;

    logic                slot_free;
    logic                last_elem;
    logic [7:0]          elem;

    assign slot_free = !r_ovalid || !i_stall;
    assign last_elem = (r_kind == vrr_pkg::CMD_PASS) ? (r_pos == vrr_pkg::PASS_LAST_IDX)
                                                     : (r_pos == vrr_pkg::RTAP_LAST_IDX);

    // one byte of the current burst
    always_comb begin
        elem = 8'h00;
        if (r_kind == vrr_pkg::CMD_PASS) begin
            elem = i_head[r_pos];
        end else begin
            unique case (r_pos)
                4'd2:    elem = vrr_pkg::RT_LEN_BYTE;
                4'd4:    elem = vrr_pkg::RT_PRESENT_BYTE;
                4'd8:    elem = i_header_flags;
                4'd10:   elem = i_channel_mhz[7:0];
                4'd11:   elem = i_channel_mhz[15:8];
                4'd12:   elem = i_channel_flags[7:0];
                4'd13:   elem = i_channel_flags[15:8];
                4'd14:   elem = r_sig;
                default: elem = 8'h00;   // fixed zeros, including the pad byte
            endcase
        end
    end

    always_comb begin
        n_active     = r_active;
        n_kind       = r_kind;
        n_pos        = r_pos;
        n_last       = r_last;
        n_sig        = r_sig;
        n_ovalid     = r_ovalid;
        n_obyte      = r_obyte;
        n_olast      = r_olast;
        n_odrop      = r_odrop;
        o_pop        = 1'b0;
        o_burst_done = 1'b0;
        if (slot_free) begin
            if (r_active) begin
                n_ovalid = 1'b1;
                n_obyte  = elem;
                n_olast  = r_last && last_elem;
                n_odrop  = 1'b0;
                n_pos    = r_pos + 4'd1;
                if (last_elem) begin
                    n_active     = 1'b0;
                    o_burst_done = (r_kind == vrr_pkg::CMD_PASS);
                end
            end else if (i_cmd_valid) begin
                o_pop    = 1'b1;
                n_ovalid = 1'b1;
                n_olast  = i_cmd.last;
                n_odrop  = 1'b0;
                unique case (i_cmd.kind)
                    vrr_pkg::CMD_BYTE: begin
                        n_obyte = i_cmd.data;
                    end
                    vrr_pkg::CMD_DROP: begin
                        n_obyte = 8'h00;
                        n_olast = 1'b1;
                        n_odrop = 1'b1;
                    end
                    vrr_pkg::CMD_PASS: begin
                        n_obyte  = i_head[0];
                        n_olast  = 1'b0;
                        n_active = 1'b1;
                        n_kind   = vrr_pkg::CMD_PASS;
                        n_pos    = 4'd1;
                        n_last   = i_cmd.last;
                    end
                    vrr_pkg::CMD_RTAP: begin
                        n_obyte  = 8'h00;
                        n_olast  = 1'b0;
                        n_active = 1'b1;
                        n_kind   = vrr_pkg::CMD_RTAP;
                        n_pos    = 4'd1;
                        n_last   = i_cmd.last;
                        n_sig    = i_cmd.data;
                    end
                    default: begin
                        n_obyte = i_cmd.data;
                    end
                endcase
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_pos   <= n_pos;
        r_last  <= n_last;
        r_sig   <= n_sig;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_odrop <= n_odrop;
    end

    assign o_valid   = r_ovalid;
    assign o_byte    = r_obyte;
    assign o_last    = r_olast;
    assign o_dropped = r_odrop;

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odrop) |-> (r_olast && (r_obyte == 8'h00)))
        else $error("drop marker not a lone zero last byte");

    a_no_pop_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_active)
        else $error("command taken during a burst");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst_done |=> !r_active)
        else $error("burst still active after its last byte");

endmodule

`default_nettype wire

// ===== rtl/vendor_rx_to_radiotap_rewriter.sv =====
// Path: an accepted byte that yields output goes through the command queue, then
// the output register, to o_out_*. Throughput: one input byte per cycle when not
// stalled; a header burst (16 or 15 bytes) drains at one byte per cycle from the
// back end while i_out_stall is low, so the input stalls once the queue fills.
// Reset: i_rst_n synchronous, active low; clears parser state, queue and output
// valid, loads configuration defaults. No clearing pass; ready the next cycle.
`default_nettype none

module vendor_rx_to_radiotap_rewriter #(
    parameter int QUEUE_DEPTH = 4    // command queue entries, power of two
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input byte channel
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_in_last,
    // output byte channel
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic              o_dropped,
    // configuration writes
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_wdata
);

    // Configuration registers feed the radiotap header bytes.
    logic [15:0] r_channel_mhz;
    logic [15:0] r_channel_flags;
    logic [7:0]  r_header_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mhz   <= vrr_pkg::RST_CHANNEL_MHZ;
            r_channel_flags <= vrr_pkg::RST_CHANNEL_FLAGS;
            r_header_flags  <= vrr_pkg::RST_HEADER_FLAGS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vrr_pkg::CFG_CHANNEL_MHZ:   r_channel_mhz   <= i_cfg_wdata;
                vrr_pkg::CFG_CHANNEL_FLAGS: r_channel_flags <= i_cfg_wdata;
                vrr_pkg::CFG_HEADER_FLAGS:  r_header_flags  <= i_cfg_wdata[7:0];
                default: ;                  // unused index, write ignored
            endcase
        end
    end

    // Front end -> queue -> back end. Each accepted byte makes at most one
    // command; bursts expand in the back end.
    vrr_pkg::t_cmd    front_cmd;
    logic             front_push;
    vrr_pkg::t_cmd    q_cmd;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic             burst_done;
    logic [15:0][7:0] head;

    vrr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_byte       (i_in_byte),
        .i_last       (i_in_last),
        .o_push       (front_push),
        .o_cmd        (front_cmd),
        .i_full       (q_full),
        .i_burst_done (burst_done),
        .o_head       (head)
    );

    vrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    vrr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .i_head          (head),
        .i_channel_mhz   (r_channel_mhz),
        .i_channel_flags (r_channel_flags),
        .i_header_flags  (r_header_flags),
        .o_burst_done    (burst_done),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_byte          (o_out_byte),
        .o_last          (o_out_last),
        .o_dropped       (o_dropped)
    );

endmodule

`default_nettype wire
